>>> rtl/core/mfba_pkg.sv
// Shared widths, register indexes and control/status bundles for the max-flow block.
package mfba_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int FLOW_W           = 48;
   localparam int VTX_W            = 6;
   localparam int ECAP_W           = 31;
   localparam int VCNT_W           = 7;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 7;

   localparam logic [VTX_W-1:0]  SOURCE_RESET = 6'd0;
   localparam logic [VTX_W-1:0]  SINK_RESET   = 6'd1;
   localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE = 2'd0,
      CSR_SINK   = 2'd1,
      CSR_VCOUNT = 2'd2
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_step;
      logic edge_capture;
      logic ld_read;
      logic ld_wr1;
      logic ld_wr2;
      logic flow_clear;
      logic bfs_init;
      logic q_pop;
      logic u_load;
      logic scan_issue;
      logic scan_check;
      logic walk_start;
      logic neck_init;
      logic walk_par;
      logic walk_cap;
      logic w1_min;
      logic w2_sub;
      logic w2_add;
      logic flow_add;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic edge_ok;
      logic edge_last;
      logic degenerate;
      logic q_empty;
      logic scan_last;
      logic found;
      logic walk_done;
   } dp_status_type;

endpackage

>>> rtl/core/mfba_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module mfba_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [DATA_W-1:0]        rd_data_a,
   output logic [DATA_W-1:0]        rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> rtl/core/mfba_dp.sv
// Datapath: config registers, residual matrix, search queue, parents, path walk.
module mfba_dp #(
   parameter int MAX_VERTICES = mfba_pkg::MAX_VERTICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mfba_pkg::ctl_cmd_type           cmd,
   output mfba_pkg::dp_status_type         status,
   input  logic                            req_edge_present,
   input  logic [mfba_pkg::VTX_W-1:0]      req_from_vertex,
   input  logic [mfba_pkg::VTX_W-1:0]      req_to_vertex,
   input  logic [mfba_pkg::ECAP_W-1:0]     req_edge_capacity,
   input  logic                            req_last_edge,
   input  logic                            csr_wr_en,
   input  logic [mfba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mfba_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [mfba_pkg::FLOW_W-1:0]     flow_value
);
   import mfba_pkg::*;

   localparam int VW        = $clog2(MAX_VERTICES);
   localparam int NW        = VW + 1;
   localparam int AW        = 2 * VW;
   localparam int RES_DEPTH = 1 << AW;

   function automatic logic [FLOW_W-1:0] sat_add(input logic [FLOW_W-1:0] a,
                                                 input logic [FLOW_W-1:0] b);
      logic [FLOW_W:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         return s[FLOW_W] ? {FLOW_W{1'b1}} : s[FLOW_W-1:0];
      end
   endfunction

   logic [VTX_W-1:0]  src_ff, snk_ff;
   logic [VCNT_W-1:0] vcnt_ff;
   logic [AW-1:0]     clr_ff;
   logic [VW-1:0]     e_from_ff, e_to_ff;
   logic [ECAP_W-1:0] e_cap_ff;
   logic              e_ok_ff, e_last_ff;
   logic [FLOW_W-1:0] ld1_ff, flow_ff, neck_ff;
   logic [MAX_VERTICES-1:0] vis_ff;
   logic [NW-1:0]     head_ff, tail_ff, steps_ff;
   logic [VW-1:0]     u_ff, v_ff, vd_ff, cur_ff, p_ff;
   logic              chk_ff;

   logic [NW-1:0]     n_w;
   logic [VW-1:0]     s_v, t_v;
   logic [FLOW_W-1:0] cap_x, ld_sum1;
   logic [FLOW_W-1:0] res_ra, res_rb, res_wd;
   logic [AW-1:0]     res_wa, res_raa, res_rab;
   logic              res_we, res_re;
   logic [VW-1:0]     par_rd, q_rd, par_wa, par_wd, q_wa, q_wd;
   logic              discovered, found, enq;

   assign n_w   = (32'(vcnt_ff) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcnt_ff);
   assign s_v   = VW'(src_ff);
   assign t_v   = VW'(snk_ff);
   assign cap_x = FLOW_W'(e_cap_ff);
   assign ld_sum1 = sat_add(res_ra, cap_x);

   assign discovered = chk_ff & cmd.scan_check & ~vis_ff[vd_ff] & (res_ra != '0);
   assign found      = discovered & (vd_ff == t_v);
   assign enq        = discovered & ~found & (32'(tail_ff) < MAX_VERTICES);

   // residual matrix ports
   always_comb begin
      res_we = 1'b0;
      res_wa = '0;
      res_wd = '0;
      if (cmd.clr_step) begin
         res_we = 1'b1;
         res_wa = clr_ff;
      end else if (cmd.ld_wr1) begin
         res_we = 1'b1;
         res_wa = {e_from_ff, e_to_ff};
         res_wd = ld_sum1;
      end else if (cmd.ld_wr2) begin
         // self loop: second add lands on the entry just written
         res_we = 1'b1;
         res_wa = {e_to_ff, e_from_ff};
         res_wd = (e_from_ff == e_to_ff) ? sat_add(ld1_ff, cap_x) : sat_add(res_rb, cap_x);
      end else if (cmd.w2_sub) begin
         res_we = 1'b1;
         res_wa = {p_ff, cur_ff};
         res_wd = res_ra - neck_ff;
      end else if (cmd.w2_add) begin
         res_we = 1'b1;
         res_wa = {cur_ff, p_ff};
         res_wd = sat_add(res_rb, neck_ff);
      end
   end

   always_comb begin
      res_raa = '0;
      res_rab = '0;
      if (cmd.ld_read) begin
         res_raa = {e_from_ff, e_to_ff};
         res_rab = {e_to_ff, e_from_ff};
      end else if (cmd.scan_issue) begin
         res_raa = {u_ff, v_ff};
      end else if (cmd.walk_cap) begin
         res_raa = {par_rd, cur_ff};
         res_rab = {cur_ff, par_rd};
      end
   end
   assign res_re = cmd.ld_read | cmd.scan_issue | cmd.walk_cap;

   assign par_wa = cmd.bfs_init ? s_v : vd_ff;
   assign par_wd = cmd.bfs_init ? s_v : u_ff;
   assign q_wa   = cmd.bfs_init ? '0 : tail_ff[VW-1:0];
   assign q_wd   = cmd.bfs_init ? s_v : vd_ff;

   mfba_ram #(.DATA_W(FLOW_W), .DEPTH(RES_DEPTH)) u_res (
      .clock     (clock),
      .wr_en     (res_we),
      .wr_addr   (res_wa),
      .wr_data   (res_wd),
      .rd_en     (res_re),
      .rd_addr_a (res_raa),
      .rd_addr_b (res_rab),
      .rd_data_a (res_ra),
      .rd_data_b (res_rb)
   );

   mfba_ram #(.DATA_W(VW), .DEPTH(MAX_VERTICES)) u_par (
      .clock     (clock),
      .wr_en     (cmd.bfs_init | discovered),
      .wr_addr   (par_wa),
      .wr_data   (par_wd),
      .rd_en     (cmd.walk_par),
      .rd_addr_a (cur_ff),
      .rd_addr_b (cur_ff),
      .rd_data_a (par_rd),
      .rd_data_b ()
   );

   mfba_ram #(.DATA_W(VW), .DEPTH(MAX_VERTICES)) u_queue (
      .clock     (clock),
      .wr_en     (cmd.bfs_init | enq),
      .wr_addr   (q_wa),
      .wr_data   (q_wd),
      .rd_en     (cmd.q_pop),
      .rd_addr_a (head_ff[VW-1:0]),
      .rd_addr_b (head_ff[VW-1:0]),
      .rd_data_a (q_rd),
      .rd_data_b ()
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff  <= SOURCE_RESET;
         snk_ff  <= SINK_RESET;
         vcnt_ff <= VCOUNT_RESET;
         clr_ff  <= '0;
         chk_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SOURCE: src_ff  <= csr_wdata[VTX_W-1:0];
               CSR_SINK:   snk_ff  <= csr_wdata[VTX_W-1:0];
               CSR_VCOUNT: vcnt_ff <= csr_wdata[VCNT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         chk_ff <= cmd.scan_issue;
      end

      if (cmd.edge_capture) begin
         e_ok_ff   <= req_edge_present && (32'(req_from_vertex) < MAX_VERTICES)
                      && (32'(req_to_vertex) < MAX_VERTICES);
         e_last_ff <= req_last_edge;
         e_from_ff <= VW'(req_from_vertex);
         e_to_ff   <= VW'(req_to_vertex);
         e_cap_ff  <= req_edge_capacity;
      end
      if (cmd.ld_wr1) begin
         ld1_ff <= ld_sum1;
      end

      if (cmd.flow_clear) begin
         flow_ff <= '0;
      end else if (cmd.flow_add) begin
         flow_ff <= sat_add(flow_ff, neck_ff);
      end

      if (cmd.bfs_init) begin
         vis_ff      <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << s_v;
         head_ff     <= '0;
         tail_ff     <= NW'(1);
      end else begin
         if (discovered && !found) begin
            vis_ff[vd_ff] <= 1'b1;
         end
         if (enq) begin
            tail_ff <= tail_ff + NW'(1);
         end
         if (cmd.q_pop) begin
            head_ff <= head_ff + NW'(1);
         end
      end

      if (cmd.u_load) begin
         u_ff <= q_rd;
         v_ff <= '0;
      end else if (cmd.scan_issue) begin
         v_ff  <= v_ff + VW'(1);
         vd_ff <= v_ff;
      end

      if (cmd.neck_init) begin
         neck_ff <= {FLOW_W{1'b1}};
      end else if (cmd.w1_min && (res_ra < neck_ff)) begin
         neck_ff <= res_ra;
      end

      if (cmd.walk_start) begin
         cur_ff   <= t_v;
         steps_ff <= '0;
      end else if (cmd.w1_min || cmd.w2_add) begin
         cur_ff   <= p_ff;
         steps_ff <= steps_ff + NW'(1);
      end
      if (cmd.walk_cap) begin
         p_ff <= par_rd;
      end
   end

   assign status.clr_last   = &clr_ff;
   assign status.edge_ok    = e_ok_ff;
   assign status.edge_last  = e_last_ff;
   assign status.degenerate = (32'(src_ff) >= 32'(n_w)) || (32'(snk_ff) >= 32'(n_w))
                              || (src_ff == snk_ff);
   assign status.q_empty    = head_ff >= tail_ff;
   assign status.scan_last  = ({1'b0, v_ff} == (n_w - NW'(1)));
   assign status.found      = found;
   assign status.walk_done  = (cur_ff == s_v) || (steps_ff >= n_w);

   assign flow_value = flow_ff;

endmodule

>>> rtl/core/mfba_ctrl.sv
// Controller: sequences clearing, edge loading, searches and augmentation.
module mfba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output mfba_pkg::ctl_cmd_type   cmd,
   input  mfba_pkg::dp_status_type status
);
   import mfba_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LD_RD, ST_LD_WR1, ST_LD_WR2, ST_CHECK,
      ST_BFS_INIT, ST_POP, ST_U, ST_SCAN, ST_DRAIN,
      ST_W1_INIT, ST_W1_PAR, ST_W1_CAP, ST_W1_MIN,
      ST_W2_INIT, ST_W2_PAR, ST_W2_CAP, ST_W2_SUB, ST_W2_ADD,
      ST_FLOW, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.edge_capture = 1'b1;
               state_in = ST_LD_RD;
            end
         end
         ST_LD_RD: begin
            if (status.edge_ok) begin
               cmd.ld_read = 1'b1;
               state_in = ST_LD_WR1;
            end else if (status.edge_last) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LD_WR1: begin
            cmd.ld_wr1 = 1'b1;
            state_in = ST_LD_WR2;
         end
         ST_LD_WR2: begin
            cmd.ld_wr2 = 1'b1;
            state_in = status.edge_last ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            cmd.flow_clear = 1'b1;
            state_in = status.degenerate ? ST_DONE : ST_BFS_INIT;
         end
         ST_BFS_INIT: begin
            cmd.bfs_init = 1'b1;
            state_in = ST_POP;
         end
         ST_POP: begin
            if (status.q_empty) begin
               state_in = ST_DONE;
            end else begin
               cmd.q_pop = 1'b1;
               state_in = ST_U;
            end
         end
         ST_U: begin
            cmd.u_load = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_check = 1'b1;
            cmd.scan_issue = 1'b1;
            if (status.found) state_in = ST_W1_INIT;
            else if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.scan_check = 1'b1;
            state_in = status.found ? ST_W1_INIT : ST_POP;
         end
         ST_W1_INIT: begin
            cmd.walk_start = 1'b1;
            cmd.neck_init  = 1'b1;
            state_in = ST_W1_PAR;
         end
         ST_W1_PAR: begin
            if (status.walk_done) begin
               state_in = ST_W2_INIT;
            end else begin
               cmd.walk_par = 1'b1;
               state_in = ST_W1_CAP;
            end
         end
         ST_W1_CAP: begin
            cmd.walk_cap = 1'b1;
            state_in = ST_W1_MIN;
         end
         ST_W1_MIN: begin
            cmd.w1_min = 1'b1;
            state_in = ST_W1_PAR;
         end
         ST_W2_INIT: begin
            cmd.walk_start = 1'b1;
            state_in = ST_W2_PAR;
         end
         ST_W2_PAR: begin
            if (status.walk_done) begin
               state_in = ST_FLOW;
            end else begin
               cmd.walk_par = 1'b1;
               state_in = ST_W2_CAP;
            end
         end
         ST_W2_CAP: begin
            cmd.walk_cap = 1'b1;
            state_in = ST_W2_SUB;
         end
         ST_W2_SUB: begin
            cmd.w2_sub = 1'b1;
            state_in = ST_W2_ADD;
         end
         ST_W2_ADD: begin
            cmd.w2_add = 1'b1;
            state_in = ST_W2_PAR;
         end
         ST_FLOW: begin
            cmd.flow_add = 1'b1;
            state_in = ST_BFS_INIT;
         end
         ST_DONE: begin
            state_in = ST_CLEAR;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_in == ST_DONE);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");
   a_found_in_scan: assert property (@(posedge clock) disable iff (reset)
      status.found |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("sink discovery outside the neighbor scan");
   a_result_after_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (state_ff == ST_CLEAR))
      else $error("matrix clear did not follow the result");
`endif

endmodule

>>> rtl/core/max_flow_bfs_augment.sv
// Top level of the Edmonds-Karp maximum-flow engine.
//
// Usage:
//  - Edge items enter on req_* and are accepted on a rising edge with start
//    high and busy low. Each edge adds its capacity to both directions of the
//    residual matrix; parallel edges accumulate, sums saturate at 2^48-1.
//  - An edge item reads both matrix entries, then makes two writes; empty or
//    out-of-range items skip both the read and the writes.
//  - The item with req_last_edge set starts the flow run: repeated BFS from
//    source to sink, each search scanning one matrix entry per cycle (one of
//    two residual RAM read ports). Each dequeued vertex is popped, loaded and
//    scanned; a found path gets a bottleneck walk (parent, capacity, min) and
//    an update walk (parent, capacity, sub, add). Latency is data dependent.
//  - The result appears on rsp_flow_value with rsp_valid high for one cycle;
//    the receiver cannot stall, it must take it then.
//  - After each result, and after reset, the residual matrix is cleared one
//    entry per cycle: MAX_VERTICES' rounded-up power of two, squared (4096
//    entries at the default). busy stays high throughout.
//  - csr_* writes source, sink and vertex count; the user must do so only
//    while idle, as the block does not enforce it; reset values 0, 1 and 64.
module max_flow_bfs_augment #(
   parameter int MAX_VERTICES = mfba_pkg::MAX_VERTICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_edge_present,
   input  logic [mfba_pkg::VTX_W-1:0]      req_from_vertex,
   input  logic [mfba_pkg::VTX_W-1:0]      req_to_vertex,
   input  logic [mfba_pkg::ECAP_W-1:0]     req_edge_capacity,
   input  logic                            req_last_edge,
   output logic                            rsp_valid,
   output logic [mfba_pkg::FLOW_W-1:0]     rsp_flow_value,
   input  logic                            csr_wr_en,
   input  logic [mfba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mfba_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mfba_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequencer: owns the state machine and the result strobe
   mfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: matrix, queue, parent table, counters and flow accumulator
   mfba_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_edge_present  (req_edge_present),
      .req_from_vertex   (req_from_vertex),
      .req_to_vertex     (req_to_vertex),
      .req_edge_capacity (req_edge_capacity),
      .req_last_edge     (req_last_edge),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .flow_value        (rsp_flow_value)
   );

endmodule
